>>> src/tfc_pkg.sv
// Shared types, register indexes and status codes of the track fusion confirmation unit.
package tfc_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_WINDOW   = 3'd0,
        CFG_CAM_EXP  = 3'd1,
        CFG_RAD_EXP  = 3'd2,
        CFG_ACC_PCT  = 3'd3,
        CFG_DEL_PCT  = 3'd4,
        CFG_HOLDOFF  = 3'd5
    } cfg_idx_t;

    // Track status codes.
    localparam logic [1:0] ST_CAMERA = 2'd0;
    localparam logic [1:0] ST_RADAR  = 2'd1;
    localparam logic [1:0] ST_FUSED  = 2'd2;
    localparam logic [1:0] ST_UNUSED = 2'd3;

    // Item function codes.
    localparam logic FN_REPORT = 1'b0;
    localparam logic FN_DELETE = 1'b1;

    // Sensor codes.
    localparam logic SNS_CAMERA = 1'b0;
    localparam logic SNS_RADAR  = 1'b1;

    // Register reset values.
    localparam logic [15:0] WINDOW_RST  = 16'd1000;
    localparam logic [5:0]  CAM_EXP_RST = 6'd10;
    localparam logic [5:0]  RAD_EXP_RST = 6'd10;
    localparam logic [6:0]  ACC_PCT_RST = 7'd70;
    localparam logic [6:0]  DEL_PCT_RST = 7'd10;
    localparam logic [15:0] HOLDOFF_RST = 16'd500;
    localparam logic [15:0] PCT_SCALE   = 16'd100;

    typedef struct packed {
        logic        func;
        logic [5:0]  track_id;
        logic        sensor;
        logic        seen_match;
        logic [31:0] now_ms;
        logic [1:0]  status_in;
    } item_t;

    typedef struct packed {
        logic [1:0] status_out;
        logic       delete_flag;
        logic       evaluated;
        logic       new_track;
    } result_t;

endpackage

>>> src/tfc_if.sv
// Handshake channels of the track fusion confirmation unit.
interface tfc_in_if;
    import tfc_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tfc_out_if;
    import tfc_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> src/track_fusion_confirmation_unit.sv
// Top level of the track fusion confirmation unit: track table, histories and sequencer.
//
//   Channel  Dir  Word
//   cfg      in   register index and write data
//   req      in   one report or delete item
//   rsp      out  status, delete flag, evaluated, new track
//
// A report prunes old entries from the reporting sensor's history; when the window
// has elapsed it then walks both histories up to the larger of the two history
// counts. Each history entry costs a read and a check of the history memory. A
// delete skips both steps, and an out-of-range track id also skips the table.
// After reset a clearing pass over all TRACKS entries empties the track table; no item
// is taken during it. A stalled result holds the sequencer in its final state.
module track_fusion_confirmation_unit
    import tfc_pkg::*;
#(
    parameter int TRACKS        = 64,
    parameter int HISTORY_DEPTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    tfc_cfg_if.sink   cfg,
    tfc_in_if.sink    req,
    tfc_out_if.source rsp
);

    localparam int TW         = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int HW         = $clog2(HISTORY_DEPTH);
    localparam int CW         = $clog2(HISTORY_DEPTH + 1);
    localparam int HIST_WORDS = TRACKS * HISTORY_DEPTH;
    localparam int AW         = $clog2(HIST_WORDS);

    typedef struct packed {
        logic          valid;
        logic [31:0]   base;
        logic [HW-1:0] c_head;
        logic [CW-1:0] c_cnt;
        logic [HW-1:0] r_head;
        logic [CW-1:0] r_cnt;
    } trk_t;

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_TRK     = 10'b0000000100,
        S_PR_REQ  = 10'b0000001000,
        S_PR_CHK  = 10'b0000010000,
        S_WIN     = 10'b0000100000,
        S_CNT_REQ = 10'b0001000000,
        S_CNT_CHK = 10'b0010000000,
        S_DECIDE  = 10'b0100000000,
        S_FIN     = 10'b1000000000
    } state_t;

    // Ring index wrap: the sum of two values below the depth stays below twice it.
    function automatic logic [HW-1:0] wrap(input logic [HW:0] s);
        logic [HW:0] d;
        d = (HW + 1)'(HISTORY_DEPTH);
        if (s >= d)
            return HW'(s - d);
        else
            return HW'(s);
    endfunction

    // Configuration registers.
    logic [15:0] window_reg;
    logic [5:0]  cam_exp_reg;
    logic [5:0]  rad_exp_reg;
    logic [6:0]  acc_pct_reg;
    logic [6:0]  del_pct_reg;
    logic [15:0] holdoff_reg;

    state_t        state_reg, state_next;
    logic [TW-1:0] clr_idx_reg;
    item_t         item_reg;
    logic [TW-1:0] idx_reg;
    trk_t          trk_reg;
    logic          wb_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] cam_n_reg, rad_n_reg;
    logic          cam_st_reg, rad_st_reg;
    result_t       res_reg;
    logic          rsp_valid_reg;
    result_t       rsp_data_reg;

    // Memories.
    trk_t          trk_mem [TRACKS];
    logic          trk_we;
    logic [TW-1:0] trk_waddr, trk_raddr;
    trk_t          trk_wdata, trk_rdata;

    logic [32:0]   cam_mem [HIST_WORDS];
    logic [32:0]   rad_mem [HIST_WORDS];
    logic          cam_we, rad_we;
    logic [AW-1:0] hist_waddr, cam_raddr, rad_raddr;
    logic [32:0]   hist_wdata, cam_rdata, rad_rdata;

    // Item decode.
    logic          in_range;
    logic [1:0]    in_status;
    item_t         in_item;
    logic [AW-1:0] hbase;
    logic [31:0]   keep;

    assign in_range  = (32'(req.data.track_id) < 32'(TRACKS));
    assign in_status = (req.data.status_in == ST_UNUSED) ? ST_CAMERA : req.data.status_in;
    assign hbase     = AW'(idx_reg) * AW'(HISTORY_DEPTH);
    assign keep      = {15'd0, window_reg, 1'b0};

    // Incoming word with the unused status code folded onto camera.
    always_comb
    begin
        in_item           = req.data;
        in_item.status_in = in_status;
    end

    // Track entry after creation and after the push.
    trk_t          trk_new;
    logic [HW-1:0] push_pos;
    logic [HW-1:0] p_head;
    logic [CW-1:0] p_cnt;

    always_comb
    begin
        trk_new = trk_rdata;
        if (!trk_rdata.valid)
        begin
            trk_new.valid  = 1'b1;
            trk_new.base   = item_reg.now_ms;
            trk_new.c_head = '0;
            trk_new.c_cnt  = '0;
            trk_new.r_head = '0;
            trk_new.r_cnt  = '0;
        end
        p_head = (item_reg.sensor == SNS_RADAR) ? trk_new.r_head : trk_new.c_head;
        p_cnt  = (item_reg.sensor == SNS_RADAR) ? trk_new.r_cnt : trk_new.c_cnt;
        if (32'(p_cnt) >= 32'(HISTORY_DEPTH))
        begin
            push_pos = p_head;
            p_head   = wrap({1'b0, p_head} + (HW + 1)'(1));
        end
        else
        begin
            push_pos = wrap({1'b0, p_head} + (HW + 1)'(p_cnt));
            p_cnt    = p_cnt + CW'(1);
        end
        if (item_reg.sensor == SNS_RADAR)
        begin
            trk_new.r_head = p_head;
            trk_new.r_cnt  = p_cnt;
        end
        else
        begin
            trk_new.c_head = p_head;
            trk_new.c_cnt  = p_cnt;
        end
    end

    // Pruning view of the reporting sensor's history.
    logic [HW-1:0] pr_head;
    logic [CW-1:0] pr_cnt;
    logic [32:0]   pr_word;
    logic          pr_drop;

    assign pr_head = (item_reg.sensor == SNS_RADAR) ? trk_reg.r_head : trk_reg.c_head;
    assign pr_cnt  = (item_reg.sensor == SNS_RADAR) ? trk_reg.r_cnt : trk_reg.c_cnt;
    assign pr_word = (item_reg.sensor == SNS_RADAR) ? rad_rdata : cam_rdata;
    assign pr_drop = ((item_reg.now_ms - pr_word[32:1]) > keep);

    // Counting view of both histories.
    logic [CW-1:0] cnt_max;
    logic          win_open;
    logic          cam_in, rad_in;
    logic          cam_start, rad_start;

    assign cnt_max  = (trk_reg.r_cnt > trk_reg.c_cnt) ? trk_reg.r_cnt : trk_reg.c_cnt;
    assign win_open = ((item_reg.now_ms - trk_reg.base) >= {16'd0, window_reg});
    assign cam_in   = (i_reg < trk_reg.c_cnt);
    assign rad_in   = (i_reg < trk_reg.r_cnt);
    assign cam_start = cam_st_reg
        || ((item_reg.now_ms - cam_rdata[32:1]) <= {16'd0, window_reg});
    assign rad_start = rad_st_reg
        || ((item_reg.now_ms - rad_rdata[32:1]) <= {16'd0, window_reg});

    // Rate decision.
    logic [15:0] rc100, cc100, r_acc, c_acc, r_del, c_del, r_str, c_str;
    logic        r_ok, c_ok, del_hit;
    logic [1:0]  dec_status;
    logic        dec_move;

    always_comb
    begin
        rc100   = 16'(rad_n_reg) * PCT_SCALE;
        cc100   = 16'(cam_n_reg) * PCT_SCALE;
        r_acc   = 16'(acc_pct_reg) * 16'(rad_exp_reg);
        c_acc   = 16'(acc_pct_reg) * 16'(cam_exp_reg);
        r_del   = 16'(del_pct_reg) * 16'(rad_exp_reg);
        c_del   = 16'(del_pct_reg) * 16'(cam_exp_reg);
        r_str   = 16'(rad_n_reg) * 16'(cam_exp_reg);
        c_str   = 16'(cam_n_reg) * 16'(rad_exp_reg);
        r_ok    = (rc100 >= r_acc);
        c_ok    = (cc100 >= c_acc);
        del_hit = (rc100 < r_del) && (cc100 < c_del);
        dec_status = item_reg.status_in;
        dec_move   = 1'b0;
        if (r_ok && c_ok && item_reg.status_in != ST_FUSED)
        begin
            dec_status = ST_FUSED;
            dec_move   = 1'b1;
        end
        else if (!r_ok && !c_ok && item_reg.status_in == ST_FUSED)
        begin
            dec_status = (r_str > c_str) ? ST_RADAR : ST_CAMERA;
            dec_move   = 1'b1;
        end
    end

    // Configuration writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= WINDOW_RST;
            cam_exp_reg <= CAM_EXP_RST;
            rad_exp_reg <= RAD_EXP_RST;
            acc_pct_reg <= ACC_PCT_RST;
            del_pct_reg <= DEL_PCT_RST;
            holdoff_reg <= HOLDOFF_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_WINDOW:  window_reg  <= cfg.wdata;
                CFG_CAM_EXP: cam_exp_reg <= cfg.wdata[5:0];
                CFG_RAD_EXP: rad_exp_reg <= cfg.wdata[5:0];
                CFG_ACC_PCT: acc_pct_reg <= cfg.wdata[6:0];
                CFG_DEL_PCT: del_pct_reg <= cfg.wdata[6:0];
                CFG_HOLDOFF: holdoff_reg <= cfg.wdata;
                default:     ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (clr_idx_reg == TW'(TRACKS - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (req.valid)
                    state_next = in_range ? S_TRK : S_FIN;
            S_TRK:
                state_next = (item_reg.func == FN_DELETE) ? S_FIN : S_PR_REQ;
            S_PR_REQ:
                state_next = (pr_cnt == '0) ? S_WIN : S_PR_CHK;
            S_PR_CHK:
                state_next = pr_drop ? S_PR_REQ : S_WIN;
            S_WIN:
                state_next = win_open ? S_CNT_REQ : S_FIN;
            S_CNT_REQ:
                state_next = (i_reg >= cnt_max) ? S_DECIDE : S_CNT_CHK;
            S_CNT_CHK:
                state_next = S_CNT_REQ;
            S_DECIDE:
                state_next = S_FIN;
            S_FIN:
                if (!rsp_valid_reg || rsp.ready)
                    state_next = S_IDLE;
            default:
                state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_idx_reg <= clr_idx_reg + TW'(1);
        end
    end

    assign req.ready = (state_reg == S_IDLE);

    // Item datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (req.valid)
                begin
                    item_reg            <= in_item;
                    idx_reg             <= TW'(req.data.track_id);
                    wb_reg              <= in_range;
                    res_reg.status_out  <= in_status;
                    res_reg.delete_flag <= 1'b0;
                    res_reg.evaluated   <= 1'b0;
                    res_reg.new_track   <= 1'b0;
                end
            S_TRK:
            begin
                res_reg.new_track <= !trk_rdata.valid;
                if (item_reg.func == FN_DELETE)
                    trk_reg <= '0;
                else
                    trk_reg <= trk_new;
            end
            S_PR_CHK:
                if (pr_drop)
                begin
                    if (item_reg.sensor == SNS_RADAR)
                    begin
                        trk_reg.r_head <= wrap({1'b0, pr_head} + (HW + 1)'(1));
                        trk_reg.r_cnt  <= pr_cnt - CW'(1);
                    end
                    else
                    begin
                        trk_reg.c_head <= wrap({1'b0, pr_head} + (HW + 1)'(1));
                        trk_reg.c_cnt  <= pr_cnt - CW'(1);
                    end
                end
            S_WIN:
            begin
                i_reg      <= '0;
                cam_n_reg  <= '0;
                rad_n_reg  <= '0;
                cam_st_reg <= 1'b0;
                rad_st_reg <= 1'b0;
            end
            S_CNT_CHK:
            begin
                i_reg <= i_reg + CW'(1);
                if (cam_in)
                begin
                    cam_st_reg <= cam_start;
                    if (cam_start && cam_rdata[0])
                        cam_n_reg <= cam_n_reg + CW'(1);
                end
                if (rad_in)
                begin
                    rad_st_reg <= rad_start;
                    if (rad_start && rad_rdata[0])
                        rad_n_reg <= rad_n_reg + CW'(1);
                end
            end
            S_DECIDE:
            begin
                res_reg.evaluated   <= 1'b1;
                res_reg.status_out  <= dec_status;
                res_reg.delete_flag <= del_hit;
                if (dec_move)
                    trk_reg.base <= item_reg.now_ms - {16'd0, holdoff_reg};
            end
            default:
                ;
        endcase
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
        begin
            if (rsp.ready)
                rsp_valid_reg <= 1'b0;
            if (state_reg == S_FIN && (!rsp_valid_reg || rsp.ready))
                rsp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && (!rsp_valid_reg || rsp.ready))
            rsp_data_reg <= res_reg;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Track table port control: clearing pass or write-back at the end of an item.
    always_comb
    begin
        trk_we    = 1'b0;
        trk_waddr = idx_reg;
        trk_wdata = trk_reg;
        if (state_reg == S_CLEAR)
        begin
            trk_we    = 1'b1;
            trk_waddr = clr_idx_reg;
            trk_wdata = '0;
        end
        else if (state_reg == S_FIN && wb_reg && (!rsp_valid_reg || rsp.ready))
            trk_we = 1'b1;
    end

    assign trk_raddr = TW'(req.data.track_id);

    always_ff @(posedge clk)
    begin
        if (trk_we)
            trk_mem[trk_waddr] <= trk_wdata;
        trk_rdata <= trk_mem[trk_raddr];
    end

    // History port control: push write and walk reads.
    always_comb
    begin
        cam_we     = (state_reg == S_TRK) && (item_reg.func == FN_REPORT)
                     && (item_reg.sensor == SNS_CAMERA);
        rad_we     = (state_reg == S_TRK) && (item_reg.func == FN_REPORT)
                     && (item_reg.sensor == SNS_RADAR);
        hist_waddr = hbase + AW'(push_pos);
        hist_wdata = {item_reg.now_ms, item_reg.seen_match};
        if (state_reg == S_PR_REQ)
        begin
            cam_raddr = hbase + AW'(pr_head);
            rad_raddr = hbase + AW'(pr_head);
        end
        else
        begin
            cam_raddr = hbase + AW'(wrap({1'b0, trk_reg.c_head} + (HW + 1)'(i_reg)));
            rad_raddr = hbase + AW'(wrap({1'b0, trk_reg.r_head} + (HW + 1)'(i_reg)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cam_we)
            cam_mem[hist_waddr] <= hist_wdata;
        cam_rdata <= cam_mem[cam_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rad_we)
            rad_mem[hist_waddr] <= hist_wdata;
        rad_rdata <= rad_mem[rad_raddr];
    end

    // Checks.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> (32'(trk_reg.c_cnt) <= 32'(HISTORY_DEPTH)
            && 32'(trk_reg.r_cnt) <= 32'(HISTORY_DEPTH)))
        else $error("history count exceeds depth");

    a_del_eval: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.delete_flag |-> rsp.data.evaluated)
        else $error("delete flag without evaluation");

    a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_TRK || state_reg == S_FIN))
        else $error("accepted item not started");

endmodule
